>>> hdl/olid_pkg.sv
package olid_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  localparam logic [OP_W-1:0] OP_FRONT  = 2'd0;
  localparam logic [OP_W-1:0] OP_BACK   = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd2;

endpackage

>>> hdl/olid_ram.sv
module olid_ram #(
  parameter int WIDTH = olid_pkg::DATA_W,
  parameter int DEPTH = olid_pkg::CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ordered_list_insert_delete_core.sv
// Channel | Ports                                              | Direction
// in      | in_valid in_stall in_opcode in_value               | request word in
// out     | out_valid out_stall out_status out_entry_count     | result word out
//
// An insert's result is registered at the accept edge.
// Delete scans one entry a cycle from the front, then compacts the tail one
// entry a cycle through the single RAM read port.
// Synchronous active-low reset empties the list; entries are not cleared.
// A new word is taken only when idle and the result register is free or draining.
module ordered_list_insert_delete_core #(
  parameter int CAPACITY = olid_pkg::CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [olid_pkg::OP_W-1:0]             in_opcode,
  input  logic signed [olid_pkg::DATA_W-1:0]    in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [olid_pkg::STAT_W-1:0]           out_status,
  output logic [$clog2(CAPACITY+1)-1:0]         out_entry_count
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int DW     = olid_pkg::DATA_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT} state_t;

  state_t                        state_r, state_nxt;
  logic [ADDR_W-1:0]             head_r, head_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [DW-1:0]                 value_r, value_nxt;
  logic [CNT_W-1:0]              rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic                          pend_r, pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [olid_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [CNT_W-1:0]              out_count_r, out_count_nxt;

  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [DW-1:0]                 ram_wdata;
  logic                          ram_re;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [DW-1:0]                 ram_rdata;

  logic                          in_accept;
  logic                          full;
  logic [ADDR_W-1:0]             head_dec;

  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] hd,
                                             input logic [CNT_W-1:0] k);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(hd) + (CNT_W+1)'(k);
    if (s >= (CNT_W+1)'(CAPACITY)) begin
      s = s - (CNT_W+1)'(CAPACITY);
    end
    return s[ADDR_W-1:0];
  endfunction

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign head_dec  = (head_r == '0) ? ADDR_W'(CAPACITY - 1) : head_r - ADDR_W'(1);

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    value_nxt      = value_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = phys(head_r, cmp_idx_r - CNT_W'(1));
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = phys(head_r, rd_idx_r);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = olid_pkg::STATUS_DONE;
          out_count_nxt  = count_r;
          case (in_opcode)
            olid_pkg::OP_FRONT: begin
              if (full) begin
                out_status_nxt = olid_pkg::STATUS_FULL;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = head_dec;
                ram_wdata     = in_value;
                head_nxt      = head_dec;
                count_nxt     = count_r + CNT_W'(1);
                out_count_nxt = count_r + CNT_W'(1);
              end
            end
            olid_pkg::OP_BACK: begin
              if (full) begin
                out_status_nxt = olid_pkg::STATUS_FULL;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = phys(head_r, count_r);
                ram_wdata     = in_value;
                count_nxt     = count_r + CNT_W'(1);
                out_count_nxt = count_r + CNT_W'(1);
              end
            end
            olid_pkg::OP_DELETE: begin
              if (count_r == '0) begin
                out_status_nxt = olid_pkg::STATUS_NOT_FOUND;
              end else begin
                out_valid_nxt = 1'b0;
                value_nxt     = in_value;
                rd_idx_nxt    = '0;
                pend_nxt      = 1'b0;
                state_nxt     = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        if (pend_r && (ram_rdata == value_r)) begin
          rd_idx_nxt = cmp_idx_r + CNT_W'(1);
          pend_nxt   = 1'b0;
          state_nxt  = ST_SHIFT;
        end else if (pend_r && (cmp_idx_r == count_r - CNT_W'(1))) begin
          pend_nxt       = 1'b0;
          out_valid_nxt  = 1'b1;
          out_status_nxt = olid_pkg::STATUS_NOT_FOUND;
          out_count_nxt  = count_r;
          state_nxt      = ST_IDLE;
        end else if (rd_idx_r < count_r) begin
          ram_re      = 1'b1;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          cmp_idx_nxt = rd_idx_r;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      ST_SHIFT: begin
        // move entry cmp_idx down by one
        if (pend_r) begin
          ram_we = 1'b1;
        end
        if (rd_idx_r < count_r) begin
          ram_re      = 1'b1;
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          cmp_idx_nxt = rd_idx_r;
          pend_nxt    = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt      = count_r - CNT_W'(1);
            out_valid_nxt  = 1'b1;
            out_status_nxt = olid_pkg::STATUS_DONE;
            out_count_nxt  = count_r - CNT_W'(1);
            state_nxt      = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r      <= value_nxt;
    rd_idx_r     <= rd_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  olid_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> tb/testbench.sv
class list_scoreboard;
  typedef logic [$clog2(olid_pkg::CAPACITY+1)-1:0] count_t;
  typedef struct {
    logic [olid_pkg::STAT_W-1:0] status;
    count_t                      entry_count;
  } outcome_t;

  logic [olid_pkg::DATA_W-1:0] held[$];
  outcome_t                    awaited[$];
  int                          failures;

  function new();
    failures = 0;
  endfunction

  function void note_request(logic [olid_pkg::OP_W-1:0] op, logic [olid_pkg::DATA_W-1:0] val);
    outcome_t o;
    int       hit;
    o.status = olid_pkg::STATUS_DONE;
    hit = -1;
    case (op)
      olid_pkg::OP_FRONT, olid_pkg::OP_BACK: begin
        if (held.size() >= olid_pkg::CAPACITY) o.status = olid_pkg::STATUS_FULL;
        else if (op == olid_pkg::OP_FRONT) held.push_front(val);
        else held.push_back(val);
      end
      olid_pkg::OP_DELETE: begin
        foreach (held[i]) if (hit < 0 && held[i] == val) hit = i;
        if (hit < 0) o.status = olid_pkg::STATUS_NOT_FOUND;
        else held.delete(hit);
      end
      default: ;
    endcase
    o.entry_count = count_t'(held.size());
    awaited.push_back(o);
  endfunction

  function void check_result(logic [olid_pkg::STAT_W-1:0] status, count_t cnt);
    outcome_t o;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual status %0d count %0d",
               $time, status, cnt);
      failures++;
      return;
    end
    o = awaited.pop_front();
    if (status !== o.status) begin
      $display("%0t: status expected %0d actual %0d", $time, o.status, status);
      failures++;
    end
    if (cnt !== o.entry_count) begin
      $display("%0t: entry_count expected %0d actual %0d", $time, o.entry_count, cnt);
      failures++;
    end
  endfunction
endclass

module testbench;

  localparam logic [olid_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CNT_W = $clog2(olid_pkg::CAPACITY+1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [olid_pkg::OP_W-1:0]          in_opcode;
  logic signed [olid_pkg::DATA_W-1:0] in_value;
  logic                               out_valid;
  logic                               out_stall;
  logic [olid_pkg::STAT_W-1:0]        out_status;
  logic [CNT_W-1:0]                   out_entry_count;

  list_scoreboard sb = new();
  bit             calm = 1'b0;
  bit             hold_req = 1'b0;
  int             cycles = 0;

  ordered_list_insert_delete_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_count (out_entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_status, out_entry_count);
  end

  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [olid_pkg::OP_W-1:0] op,
                           input logic [olid_pkg::DATA_W-1:0] val);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(op, val);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  initial begin
    int                          n;
    int                          roll;
    bit                          filling;
    logic [olid_pkg::OP_W-1:0]   op;
    logic [olid_pkg::DATA_W-1:0] val;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_opcode <= olid_pkg::OP_FRONT;
    in_value  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(olid_pkg::OP_DELETE, 32'h0000_0005);
    send_word(OP_UNUSED, 32'hFFFF_FFFF);
    send_word(olid_pkg::OP_FRONT, 32'h7FFF_FFFF);
    send_word(olid_pkg::OP_BACK, 32'h8000_0000);
    send_word(olid_pkg::OP_FRONT, 32'h0000_0000);
    send_word(olid_pkg::OP_BACK, 32'hFFFF_FFFF);
    send_word(olid_pkg::OP_BACK, 32'h7FFF_FFFF);
    for (n = 0; n < 11; n++)
      send_word(n[0] ? olid_pkg::OP_FRONT : olid_pkg::OP_BACK, $urandom());
    send_word(olid_pkg::OP_FRONT, 32'h1234_5678);
    send_word(olid_pkg::OP_BACK, 32'h8765_4321);
    send_word(olid_pkg::OP_DELETE, 32'h7FFF_FFFF);
    send_word(olid_pkg::OP_DELETE, 32'h8000_0001);
    send_word(OP_UNUSED, 32'h0000_0000);
    send_word(olid_pkg::OP_DELETE, 32'h8000_0000);

    filling = 1'b1;
    for (n = 0; n < 900; n++) begin
      if (n % 60 == 0) filling = ($urandom_range(0, 1) == 1);
      calm = (n >= 800);
      if (n == 300) hold_req = 1'b1;
      if (n == 500) begin
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OP_UNUSED;
      else if (roll < (filling ? 75 : 35))
        op = $urandom_range(0, 1) ? olid_pkg::OP_FRONT : olid_pkg::OP_BACK;
      else op = olid_pkg::OP_DELETE;
      if (op == olid_pkg::OP_DELETE && sb.held.size() > 0 && $urandom_range(0, 3) != 0)
        val = sb.held[$urandom_range(0, sb.held.size() - 1)];
      else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: val = 32'($signed($urandom_range(0, 7)) - 4);
          4: begin
            case ($urandom_range(0, 3))
              0: val = 32'h8000_0000;
              1: val = 32'h7FFF_FFFF;
              2: val = 32'h0000_0000;
              default: val = 32'hFFFF_FFFF;
            endcase
          end
          default: val = $urandom();
        endcase
      end
      send_word(op, val);
    end
    in_valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule

>>> files.f
hdl/olid_pkg.sv
hdl/olid_ram.sv
hdl/ordered_list_insert_delete_core.sv
tb/testbench.sv
